FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the divergence mask stack RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/sdms_pkg.sv
// ----------------------------------------------------------------------------
// SIMT divergence mask stack package
// Default sizes and stream beat layouts shared by the block's modules.
// ----------------------------------------------------------------------------
package sdms_pkg;

  localparam int unsigned LanesDefault      = 32;
  localparam int unsigned StackDepthDefault = 8;

  // Stream beat widths, padded to whole bytes.
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 40;

  // Input beat: lane condition bits in tdata, branch fire flag in tuser and
  // the path done flag in tlast.

  // Output beat layout, highest bits first.
  typedef struct packed {
    logic [4:0]  pad;
    logic        diverged;
    logic        is_full;
    logic        is_empty;
    logic [31:0] lanes_on;
  } out_beat_t;

endpackage

FILE: hdl/simt_divergence_mask_stack.sv
// ----------------------------------------------------------------------------
// SIMT divergence mask stack (post-dominator reconvergence stack)
// Throughput: one beat per cycle while the output is not stalled; the result beat
// is registered, appears in the cycle after the input beat is taken and reports
// the state before update. The beat after a pop is a wait beat: its payload is
// ignored while the popped mask, read from the stack RAM, becomes active.
// Reset: all lanes active, stack empty, running; RAM contents stay undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module simt_divergence_mask_stack #(
  parameter int unsigned LANES       = sdms_pkg::LanesDefault,
  parameter int unsigned STACK_DEPTH = sdms_pkg::StackDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: lane condition bits [31:0], bit i set means lane i takes the branch
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sdms_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // tuser: branch fire flag [0], set when tdata carries a branch outcome
  input  logic                           s_axis_tuser_i,
  // tlast: path done flag, set on the beat that ends the current path
  input  logic                           s_axis_tlast_i,
  // tdata: active lanes [31:0], empty flag [32], full flag [33],
  //        diverged flag [34], zero pad [39:35]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [sdms_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  import sdms_pkg::*;

  // Stack pointer holds 0..STACK_DEPTH; the RAM address covers the entries.
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [LANES-1:0] AllLanes = '1;

  // --------------------------------------------------------------------------
  // Architectural state. The else masks live in the stack RAM; everything
  // else is small enough for flops.
  // --------------------------------------------------------------------------
  logic [LANES-1:0] cur_mask_q, cur_mask_d;
  logic [SpW-1:0]   sp_q, sp_d;
  logic             wait_q, wait_d;
  // When a push and a pop land on the same beat, the popped entry is the one
  // just written, so it is taken from this register instead of the RAM.
  logic             fwd_q;
  logic [LANES-1:0] fwd_mask_q;

  // Output stage.
  logic             out_valid_q;
  out_beat_t        out_beat_q;

  // --------------------------------------------------------------------------
  // Input beat decode.
  // --------------------------------------------------------------------------
  logic             accept;
  logic             fire;
  logic             done;
  logic [LANES-1:0] cond;
  logic [LANES-1:0] then_m;
  logic [LANES-1:0] else_m;

  // A new beat is taken whenever the output register is free or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign fire   = s_axis_tuser_i;
  assign done   = s_axis_tlast_i;
  assign cond   = s_axis_tdata_i[LANES-1:0];
  assign then_m = cond & cur_mask_q;
  assign else_m = ~cond & cur_mask_q;

  // --------------------------------------------------------------------------
  // Branch and pop update. The branch is applied first; the pop then sees the
  // stack after a possible push.
  // --------------------------------------------------------------------------
  logic             split;
  logic             push;
  logic             pop;
  logic [SpW-1:0]   sp_br;
  logic [SpW-1:0]   pop_idx;
  logic [LANES-1:0] mask_br;
  logic [LANES-1:0] ram_rdata;

  assign split = (|then_m) && (|else_m);
  // A split on a full stack drops the else lanes but still runs the then lanes.
  assign push  = !wait_q && fire && split && (sp_q < SpW'(STACK_DEPTH));
  assign sp_br = sp_q + SpW'(push);
  assign pop   = !wait_q && done && (sp_br != '0);
  assign pop_idx = sp_br - SpW'(1);

  always_comb begin
    mask_br = cur_mask_q;
    if (fire && (|then_m)) begin
      mask_br = then_m;
    end else if (fire && (|else_m)) begin
      mask_br = else_m;
    end
  end

  always_comb begin
    cur_mask_d = cur_mask_q;
    sp_d       = sp_q;
    wait_d     = wait_q;
    if (accept) begin
      if (wait_q) begin
        // Wait beat: the popped mask takes over and the payload is dropped.
        cur_mask_d = fwd_q ? fwd_mask_q : ram_rdata;
        wait_d     = 1'b0;
      end else begin
        if (done && !pop) begin
          // Path done with nothing stacked reconverges every lane.
          cur_mask_d = AllLanes;
        end else begin
          cur_mask_d = mask_br;
        end
        sp_d   = pop ? pop_idx : sp_br;
        wait_d = pop;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q  <= AllLanes;
      sp_q        <= '0;
      wait_q      <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_mask_q <= cur_mask_d;
      sp_q       <= sp_d;
      wait_q     <= wait_d;
      if (accept && pop) begin
        fwd_q <= push;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always @(posedge clk_i) begin
    if (accept && pop) begin
      fwd_mask_q <= else_m;
    end
    if (accept) begin
      out_beat_q.pad      <= '0;
      out_beat_q.diverged <= (sp_q != '0);
      out_beat_q.is_full  <= (sp_q >= SpW'(STACK_DEPTH));
      out_beat_q.is_empty <= (sp_q == '0);
      out_beat_q.lanes_on <= 32'(cur_mask_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stack RAM: else masks pushed at the stack pointer, popped one below the
  // pointer after the branch. The read result is consumed by the wait beat.
  // --------------------------------------------------------------------------
  sdms_ram #(
    .WIDTH (LANES),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(AddrW)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (accept && push),
    .waddr_i(sp_q[AddrW-1:0]),
    .wdata_i(else_m),
    .re_i   (accept && pop),
    .raddr_i(pop_idx[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_beat_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_sp_range, clk_i, rst_ni, sp_q > SpW'(STACK_DEPTH),
                "stack pointer beyond stack depth")
  `ASSERT_CLK(a_pop_waits, clk_i, rst_ni, (accept && pop) |=> wait_q,
              "pop did not enter the wait beat")
  `ASSERT_CLK(a_wait_one_beat, clk_i, rst_ni, (accept && wait_q) |=> !wait_q,
              "wait lasted more than one beat")
  `ASSERT_CLK(a_result_follows, clk_i, rst_ni, accept |=> m_axis_tvalid_o,
              "accepted beat produced no result")

endmodule

FILE: hdl/sdms_ram.sv
// ----------------------------------------------------------------------------
// SDMS generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module sdms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/sdms_status_checker.sv
// ----------------------------------------------------------------------------
// Divergence mask stack status checker
// Watches both stream channels of the mask stack, predicts one status beat per
// accepted input beat, and compares each output beat field by field.
// ----------------------------------------------------------------------------
module sdms_status_checker #(
  parameter int unsigned LANES       = sdms_pkg::LanesDefault,
  parameter int unsigned STACK_DEPTH = sdms_pkg::StackDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [sdms_pkg::InTdataW-1:0]  in_data_i,
  input  logic                           in_user_i,
  input  logic                           in_last_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [sdms_pkg::OutTdataW-1:0] out_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    outstanding_o,
  output int unsigned                    checked_o,
  output int unsigned                    overflow_drops_o,
  output int unsigned                    pops_o
);

  import sdms_pkg::*;

  localparam logic [31:0] AllLanes = 32'((64'd1 << LANES) - 64'd1);

  logic [31:0] cur_lanes;
  logic [31:0] popped_mask;
  logic [31:0] else_stack [STACK_DEPTH];
  int unsigned depth;
  bit          in_wait;
  out_beat_t   status_q [$];

  // Reports the status as it stood before this beat, then applies the beat.
  function automatic out_beat_t step_reconvergence(logic fire, logic [31:0] cond,
                                                   logic done);
    out_beat_t   now;
    logic [31:0] taken;
    logic [31:0] not_taken;
    now          = '0;
    now.lanes_on = cur_lanes & AllLanes;
    now.is_empty = (depth == 0);
    now.is_full  = (depth >= STACK_DEPTH);
    now.diverged = (depth > 0);
    taken        = cond & cur_lanes & AllLanes;
    not_taken    = ~cond & cur_lanes & AllLanes;
    // The beat after a pop only installs the popped mask.
    if (in_wait) begin
      cur_lanes = popped_mask & AllLanes;
      in_wait   = 1'b0;
      return now;
    end
    if (fire) begin
      if (taken != '0 && not_taken == '0) begin
        cur_lanes = taken;
      end else if (taken == '0 && not_taken != '0) begin
        cur_lanes = not_taken;
      end else if (taken != '0 && not_taken != '0) begin
        if (depth < STACK_DEPTH) begin
          else_stack[depth] = not_taken;
          depth++;
        end else begin
          overflow_drops_o++;
        end
        cur_lanes = taken;
      end
    end
    // The pop sees the stack after this beat's branch.
    if (done) begin
      if (depth > 0) begin
        depth--;
        popped_mask = else_stack[depth];
        in_wait     = 1'b1;
        pops_o++;
      end else begin
        cur_lanes = AllLanes;
      end
    end
    return now;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      cur_lanes        = AllLanes;
      popped_mask      = '0;
      depth            = 0;
      in_wait          = 1'b0;
      status_q.delete();
      fail_count_o     = 0;
      outstanding_o    = 0;
      checked_o        = 0;
      overflow_drops_o = 0;
      pops_o           = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        status_q.push_back(step_reconvergence(in_user_i, in_data_i[31:0], in_last_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (status_q.size() == 0) begin
          fail_count_o++;
          $error("status beat 0x%010h arrived with nothing expected", out_data_i);
        end else begin
          want = status_q.pop_front();
          check_field("active lanes", want.lanes_on, got.lanes_on);
          check_field("empty flag", 32'(want.is_empty), 32'(got.is_empty));
          check_field("full flag", 32'(want.is_full), 32'(got.is_full));
          check_field("diverged", 32'(want.diverged), 32'(got.diverged));
          checked_o++;
        end
      end
      outstanding_o = unsigned'(status_q.size());
    end
  end

endmodule

FILE: bench/tb_simt_divergence_mask_stack.sv
// ----------------------------------------------------------------------------
// Testbench for the SIMT divergence mask stack
// Drives branch and path-done beats into the stack with random gaps and
// back-pressure; a separate checker predicts and compares every status beat.
// ----------------------------------------------------------------------------
module tb_simt_divergence_mask_stack;
  import sdms_pkg::*;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;

  // While set, neither the sender nor the receiver inserts idle cycles.
  bit steady = 1'b0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned overflow_drops;
  int unsigned pops;
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  simt_divergence_mask_stack u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    // tdata: lane condition bits [31:0]
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    // tuser: branch fire flag [0]
    .s_axis_tuser_i  (s_tuser),
    // tlast: path done flag
    .s_axis_tlast_i  (s_tlast),
    // tdata: active lanes [31:0], empty flag [32], full flag [33],
    //        diverged flag [34], zero pad [39:35]
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sdms_status_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (s_tvalid),
    .in_ready_i       (s_tready),
    .in_data_i        (s_tdata),
    .in_user_i        (s_tuser),
    .in_last_i        (s_tlast),
    .out_valid_i      (m_tvalid),
    .out_ready_i      (m_tready),
    .out_data_i       (m_tdata),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .overflow_drops_o (overflow_drops),
    .pops_o           (pops)
  );

  // The receiver stalls at random, about one time in five, except during the
  // steady stretch.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Watchdog: a run that stops moving beats in either direction is hung.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= 2000) begin
      $display("tb_simt_divergence_mask_stack NOT OK");
      $finish;
    end
  end

  // Presents one beat, with an optional random gap ahead of it, and returns
  // right after the edge at which the stack takes it. Handshake signals are
  // read just after the edge, before any nonblocking update of that edge.
  task automatic send_beat(input logic fire, input logic [31:0] cond, input logic done);
    while (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fire;
    s_tdata  <= cond;
    s_tlast  <= done;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Branch conditions: mostly random, with uniform outcomes and conditions
  // that split off or keep a single lane mixed in, so that the active mask
  // stays wide enough to keep diverging and the stack can fill up.
  function automatic logic [31:0] pick_cond();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 32'd1 << $urandom_range(31);
      4, 5:    return ~(32'd1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned counted;
    int unsigned nest;
    counted = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A divergent branch and a pop in the same beat: the else
    // lanes are pushed and popped straight away, and the next beat is a wait
    // beat whose payload must be ignored.
    send_beat(1'b1, 32'h0000_0001, 1'b1);
    send_beat(1'b1, 32'hFFFF_FFFF, 1'b1);
    // Uniform branch and path done with an empty stack: all lanes come back.
    send_beat(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_beat(1'b0, 32'h0000_0000, 1'b0);
    send_beat(1'b1, 32'h0000_0000, 1'b0);
    // Peel one lane off per branch until the stack is full; the last push is
    // dropped while the then lanes still take over.
    for (int k = 1; k <= 9; k++) begin
      send_beat(1'b1, ~((32'd1 << k) - 32'd1), 1'b0);
    end
    send_beat(1'b1, 32'h8000_0000, 1'b0);
    send_beat(1'b1, 32'h7FFF_FFFF, 1'b0);
    // Pops from a full stack, each followed by a wait beat full of noise.
    send_beat(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_beat(1'b1, 32'h5A5A_A5A5, 1'b1);
    send_beat(1'b0, 32'h0000_0000, 1'b1);
    send_beat(1'b1, 32'hFFFF_FFFF, 1'b0);

    // Random part: mostly nested regions (a run of branches, then as many
    // pops, sometimes one more to hit the empty stack), with single random
    // beats as noise in between. Every beat sent here is counted.
    while (counted < 1400) begin
      steady <= (counted >= 500 && counted < 800);
      if ($urandom_range(99) < 70) begin
        nest = $urandom_range(10, 1);
        repeat (nest) begin
          send_beat(1'b1, pick_cond(), $urandom_range(9) == 0);
          counted++;
        end
        repeat (nest + $urandom_range(1)) begin
          send_beat($urandom_range(3) == 0, pick_cond(), 1'b1);
          counted++;
          send_beat(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
          counted++;
        end
      end else begin
        send_beat(1'($urandom_range(1)), pick_cond(), 1'($urandom_range(1)));
        counted++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then keep the clock running for any stray beat to show up.
    while (outstanding != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Compared %0d status beats covering %0d pops into the wait beat", checked, pops);
    $display("and %0d branch splits dropped on a full stack.", overflow_drops);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_simt_divergence_mask_stack OK");
    end else begin
      $display("tb_simt_divergence_mask_stack NOT OK");
    end
    $finish;
  end

endmodule
